// File: rtl/core/ffsa_pkg.sv
// Package for the first-fit segment allocator: status codes, request kinds,
// sequencer state codes and APB register addresses. No dependencies.
`default_nettype none
package ffsa_pkg;
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_ASCAN   = 4'd1;
	localparam logic [3:0] S_AWAIT   = 4'd2;
	localparam logic [3:0] S_FSCAN   = 4'd3;
	localparam logic [3:0] S_FWAIT   = 4'd4;
	localparam logic [3:0] S_RMV     = 4'd5;
	localparam logic [3:0] S_INSPOS  = 4'd6;
	localparam logic [3:0] S_INSWT   = 4'd7;
	localparam logic [3:0] S_SHIFT   = 4'd8;
	localparam logic [3:0] S_PUT     = 4'd9;
	localparam logic [3:0] S_DONE    = 4'd10;
	localparam logic [3:0] S_RMVWT   = 4'd11;
	localparam logic [3:0] S_SHIFTWT = 4'd12;

	localparam logic [1:0] APB_HEAP_FIRST = 2'd0;
	localparam logic [1:0] APB_HEAP_LAST  = 2'd1;
endpackage
`default_nettype wire

// File: rtl/core/first_fit_segment_allocator.sv
// Top level of the first-fit segment allocator: APB registers, the two
// segment tables and the sequencer that walks them. Uses ffsa_pkg.
// A request makes a search and then a shift of the entries behind the insert
// or remove point, one entry at a time, set by the single read port of each
// table memory.
// One request is in work at a time; the next is taken once the result is taken.
// Reset clears the heap-ready flag, counts and control registers and sets the heap window to 0..65535;
// table contents need no clearing since only entries below a count are ever read.
`default_nettype none
module first_fit_segment_allocator #(
	parameter int MAX_SEGMENTS = 32,
	parameter int HEADER_BYTES = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         func,
	input  wire  [31:0] req_size,
	input  wire  [31:0] free_addr,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [31:0] result_addr,
	output logic [1:0]  status
);
	localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam logic [CW-1:0] CMAX = CW'(MAX_SEGMENTS);
	localparam logic [32:0] HDR = 33'(HEADER_BYTES);

	logic [31:0] heap_first_q, heap_last_q;
	logic        ready_q;
	logic [3:0]  state_q;
	logic [CW-1:0] fcnt_q, ucnt_q, idx_q, pos_q;
	logic        tsel_q;   // table being modified: 0 free, 1 used
	logic [32:0] need_q;
	logic [31:0] size_q, faddr_q, ins_start_q, ins_len_q;
	logic [31:0] res_addr_q;
	logic [1:0]  res_st_q;
	logic        out_valid_q;

	// Table memories: one write and one registered read each.
	logic [31:0] fs_mem [MAX_SEGMENTS];
	logic [31:0] fl_mem [MAX_SEGMENTS];
	logic [31:0] us_mem [MAX_SEGMENTS];
	logic [31:0] ul_mem [MAX_SEGMENTS];
	logic [31:0] fs_rd_q, fl_rd_q, us_rd_q, ul_rd_q;
	logic [IW-1:0] rd_addr, wr_addr;
	logic        f_we, u_we;
	logic [31:0] wr_s, wr_l;

	always_ff @(posedge clk) begin
		if (f_we) begin
			fs_mem[wr_addr] <= wr_s;
			fl_mem[wr_addr] <= wr_l;
		end
		if (u_we) begin
			us_mem[wr_addr] <= wr_s;
			ul_mem[wr_addr] <= wr_l;
		end
		fs_rd_q <= fs_mem[rd_addr];
		fl_rd_q <= fl_mem[rd_addr];
		us_rd_q <= us_mem[rd_addr];
		ul_rd_q <= ul_mem[rd_addr];
	end

	assign pready = 1'b1;
	always_comb begin
		case (paddr[2:2])
			1'b0:    prdata = heap_first_q;
			default: prdata = heap_last_q;
		endcase
	end

	assign in_ready    = (state_q == ffsa_pkg::S_IDLE) && !out_valid_q;
	assign out_valid   = out_valid_q;
	assign result_addr = res_addr_q;
	assign status      = res_st_q;

	logic [31:0] rs, rl;
	logic [CW-1:0] tcnt;
	assign rs   = tsel_q ? us_rd_q : fs_rd_q;
	assign rl   = tsel_q ? ul_rd_q : fl_rd_q;
	assign tcnt = tsel_q ? ucnt_q : fcnt_q;

	logic [32:0] span;
	assign span = {1'b0, heap_last_q} - {1'b0, heap_first_q} + 33'd1;

	logic [32:0] ext;
	assign ext = {1'b0, ul_rd_q} + HDR;

	// Read address and writes follow the state.
	always_comb begin
		rd_addr = idx_q[IW-1:0];
		wr_addr = idx_q[IW-1:0];
		f_we = 1'b0;
		u_we = 1'b0;
		wr_s = rs;
		wr_l = rl;
		case (state_q)
			ffsa_pkg::S_IDLE: begin
				// Lazy heap setup on the first request: one segment over the window.
				wr_addr = '0;
				wr_s = heap_first_q;
				wr_l = span[32] ? 32'hFFFF_FFFF : span[31:0];
				f_we = in_valid && in_ready && !ready_q && (heap_last_q >= heap_first_q);
			end
			ffsa_pkg::S_RMV: begin
				// idx_q walks upwards; copy entry idx+1 down to idx.
				rd_addr = IW'(idx_q + CW'(1));
			end
			ffsa_pkg::S_RMVWT: begin
				rd_addr = IW'(idx_q + CW'(1));
				wr_addr = idx_q[IW-1:0];
				f_we = !tsel_q;
				u_we = tsel_q;
			end
			ffsa_pkg::S_SHIFT: begin
				// idx_q walks downwards; fetch entry idx-1.
				rd_addr = IW'(idx_q - CW'(1));
			end
			ffsa_pkg::S_SHIFTWT: begin
				wr_addr = idx_q[IW-1:0];
				f_we = !tsel_q;
				u_we = tsel_q;
			end
			ffsa_pkg::S_PUT: begin
				wr_addr = pos_q[IW-1:0];
				wr_s = ins_start_q;
				wr_l = ins_len_q;
				f_we = !tsel_q;
				u_we = tsel_q;
			end
			ffsa_pkg::S_AWAIT: begin
				// Trim a segment in place when the fit is not exact.
				wr_addr = IW'(idx_q - CW'(1));
				wr_s = fs_rd_q + need_q[31:0];
				wr_l = fl_rd_q - need_q[31:0];
				f_we = ({1'b0, fl_rd_q} > need_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_first_q <= '0;
			heap_last_q  <= 32'd65535;
			ready_q      <= 1'b0;
			state_q      <= ffsa_pkg::S_IDLE;
			fcnt_q       <= '0;
			ucnt_q       <= '0;
			idx_q        <= '0;
			pos_q        <= '0;
			tsel_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			res_st_q     <= ffsa_pkg::ST_OK;
			res_addr_q   <= '0;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr[2:2] == ffsa_pkg::APB_HEAP_FIRST[0])
					heap_first_q <= pwdata;
				else
					heap_last_q <= pwdata;
			end
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ffsa_pkg::S_IDLE: begin
					if (in_valid && in_ready) begin
						size_q  <= req_size;
						faddr_q <= free_addr;
						need_q  <= {1'b0, req_size} + HDR;
						idx_q   <= '0;
						res_addr_q <= '0;
						if (!ready_q) begin
							ready_q <= 1'b1;
							ucnt_q  <= '0;
							if (heap_last_q >= heap_first_q) begin
								fcnt_q <= CW'(1);
							end else begin
								fcnt_q <= '0;
							end
						end
						if (func == ffsa_pkg::FUNC_ALLOC) begin
							tsel_q  <= 1'b0;
							state_q <= ffsa_pkg::S_ASCAN;
						end else begin
							tsel_q  <= 1'b1;
							state_q <= ffsa_pkg::S_FSCAN;
						end
					end
				end
				ffsa_pkg::S_ASCAN: begin
					if (ready_q && ucnt_q >= CMAX) begin
						res_st_q <= ffsa_pkg::ST_FULL;
						state_q  <= ffsa_pkg::S_DONE;
					end else if (need_q == 33'd0 || idx_q >= fcnt_q) begin
						res_st_q <= ffsa_pkg::ST_MISS;
						state_q  <= ffsa_pkg::S_DONE;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= ffsa_pkg::S_AWAIT;
					end
				end
				ffsa_pkg::S_AWAIT: begin
					if ({1'b0, fl_rd_q} >= need_q) begin
						ins_start_q <= fs_rd_q;
						ins_len_q   <= size_q;
						res_addr_q  <= fs_rd_q + HDR[31:0];
						res_st_q    <= ffsa_pkg::ST_OK;
						if ({1'b0, fl_rd_q} == need_q) begin
							idx_q   <= idx_q - CW'(1);
							tsel_q  <= 1'b0;
							state_q <= ffsa_pkg::S_RMV;
						end else begin
							idx_q   <= '0;
							tsel_q  <= 1'b1;
							state_q <= ffsa_pkg::S_INSPOS;
						end
					end else begin
						state_q <= ffsa_pkg::S_ASCAN;
					end
				end
				ffsa_pkg::S_FSCAN: begin
					if (idx_q >= ucnt_q) begin
						res_st_q <= ffsa_pkg::ST_MISS;
						state_q  <= ffsa_pkg::S_DONE;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= ffsa_pkg::S_FWAIT;
					end
				end
				ffsa_pkg::S_FWAIT: begin
					if (us_rd_q + HDR[31:0] == faddr_q) begin
						if (fcnt_q >= CMAX) begin
							res_st_q <= ffsa_pkg::ST_FULL;
							state_q  <= ffsa_pkg::S_DONE;
						end else begin
							res_st_q    <= ffsa_pkg::ST_OK;
							ins_start_q <= us_rd_q;
							ins_len_q   <= ext[32] ? 32'hFFFF_FFFF : ext[31:0];
							idx_q       <= idx_q - CW'(1);
							state_q     <= ffsa_pkg::S_RMV;
						end
					end else begin
						state_q <= ffsa_pkg::S_FSCAN;
					end
				end
				ffsa_pkg::S_RMV: begin
					// Shift entries above idx down by one.
					if (idx_q + CW'(1) >= tcnt) begin
						if (tsel_q) begin
							ucnt_q <= ucnt_q - CW'(1);
						end else begin
							fcnt_q <= fcnt_q - CW'(1);
						end
						idx_q   <= '0;
						tsel_q  <= !tsel_q;
						state_q <= ffsa_pkg::S_INSPOS;
					end else begin
						state_q <= ffsa_pkg::S_RMVWT;
					end
				end
				ffsa_pkg::S_RMVWT: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= ffsa_pkg::S_RMV;
				end
				ffsa_pkg::S_INSPOS: begin
					if (idx_q >= tcnt) begin
						pos_q   <= idx_q;
						idx_q   <= tcnt;
						state_q <= ffsa_pkg::S_SHIFT;
					end else begin
						state_q <= ffsa_pkg::S_INSWT;
					end
				end
				ffsa_pkg::S_INSWT: begin
					if (rs <= ins_start_q) begin
						idx_q   <= idx_q + CW'(1);
						state_q <= ffsa_pkg::S_INSPOS;
					end else begin
						pos_q   <= idx_q;
						idx_q   <= tcnt;
						state_q <= ffsa_pkg::S_SHIFT;
					end
				end
				ffsa_pkg::S_SHIFT: begin
					// Entries from the insert point upwards move up by one.
					if (idx_q <= pos_q) begin
						state_q <= ffsa_pkg::S_PUT;
					end else begin
						state_q <= ffsa_pkg::S_SHIFTWT;
					end
				end
				ffsa_pkg::S_SHIFTWT: begin
					idx_q   <= idx_q - CW'(1);
					state_q <= ffsa_pkg::S_SHIFT;
				end
				ffsa_pkg::S_PUT: begin
					if (tsel_q) ucnt_q <= ucnt_q + CW'(1);
					else fcnt_q <= fcnt_q + CW'(1);
					state_q <= ffsa_pkg::S_DONE;
				end
				ffsa_pkg::S_DONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q     <= ffsa_pkg::S_IDLE;
					end
				end
				default: state_q <= ffsa_pkg::S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
